### src/mirrored_compare_exchange_sorter_assert.svh
// ------------------------------------------------------------------------
// Assertion macros for the mirrored compare-exchange sorter
// Concurrent checks on clk, disabled while rst_n is low.
// ------------------------------------------------------------------------
`ifndef MIRRORED_COMPARE_EXCHANGE_SORTER_ASSERT_SVH
`define MIRRORED_COMPARE_EXCHANGE_SORTER_ASSERT_SVH

// same-cycle implication
`define MCES_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MCES_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/mces_pkg.sv
// ------------------------------------------------------------------------
// mces_pkg
// Sizes, microcode step names, control word format and the microcode
// program of the mirrored compare-exchange sorter.
// ------------------------------------------------------------------------
package mces_pkg;

    localparam int CAPACITY = 16;
    localparam int VAL_W    = 32;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int PC_W     = 4;

    // microcode step addresses
    localparam logic [PC_W-1:0] S_LOAD   = PC_W'(0);
    localparam logic [PC_W-1:0] S_FIRST  = PC_W'(1);
    localparam logic [PC_W-1:0] S_TEST   = PC_W'(2);
    localparam logic [PC_W-1:0] S_CMP    = PC_W'(3);
    localparam logic [PC_W-1:0] S_WR_HI  = PC_W'(4);
    localparam logic [PC_W-1:0] S_FWD    = PC_W'(5);
    localparam logic [PC_W-1:0] S_BINIT  = PC_W'(6);
    localparam logic [PC_W-1:0] S_BWD    = PC_W'(7);
    localparam logic [PC_W-1:0] S_OSTART = PC_W'(8);
    localparam logic [PC_W-1:0] S_ORD    = PC_W'(9);
    localparam logic [PC_W-1:0] S_OUT    = PC_W'(10);

    typedef enum logic [3:0] {
        OP_LOAD,
        OP_FIRST,
        OP_READ,
        OP_WR_LO,
        OP_WR_HI,
        OP_FWD,
        OP_BINIT,
        OP_BWD,
        OP_OSTART,
        OP_ORD,
        OP_OUT
    } op_t;

    typedef enum logic [2:0] {
        C_ALWAYS,
        C_LAST_ACC,
        C_PASS_DONE,
        C_R_LE1,
        C_R_DONE,
        C_OUT
    } cond_t;

    typedef struct packed {
        op_t             op;
        cond_t           cond;
        logic [PC_W-1:0] t_true;
        logic [PC_W-1:0] t_false;
    } uword_t;

    // Control store. A pass loop (TEST, CMP, WR_HI) returns through the
    // return register to the FWD or BWD step that sets up the next pass.
    function automatic uword_t ucode(input logic [PC_W-1:0] pc);
        uword_t w;
        w = '{op: OP_LOAD, cond: C_LAST_ACC, t_true: S_FIRST, t_false: S_LOAD};
        case (pc)
            S_LOAD:   w = '{op: OP_LOAD,   cond: C_LAST_ACC,  t_true: S_FIRST,  t_false: S_LOAD};
            S_FIRST:  w = '{op: OP_FIRST,  cond: C_ALWAYS,    t_true: S_TEST,   t_false: S_TEST};
            S_TEST:   w = '{op: OP_READ,   cond: C_PASS_DONE, t_true: S_TEST,   t_false: S_CMP};
            S_CMP:    w = '{op: OP_WR_LO,  cond: C_ALWAYS,    t_true: S_WR_HI,  t_false: S_WR_HI};
            S_WR_HI:  w = '{op: OP_WR_HI,  cond: C_ALWAYS,    t_true: S_TEST,   t_false: S_TEST};
            S_FWD:    w = '{op: OP_FWD,    cond: C_R_LE1,     t_true: S_BINIT,  t_false: S_TEST};
            S_BINIT:  w = '{op: OP_BINIT,  cond: C_ALWAYS,    t_true: S_BWD,    t_false: S_BWD};
            S_BWD:    w = '{op: OP_BWD,    cond: C_R_DONE,    t_true: S_OSTART, t_false: S_TEST};
            S_OSTART: w = '{op: OP_OSTART, cond: C_ALWAYS,    t_true: S_ORD,    t_false: S_ORD};
            S_ORD:    w = '{op: OP_ORD,    cond: C_ALWAYS,    t_true: S_OUT,    t_false: S_OUT};
            S_OUT:    w = '{op: OP_OUT,    cond: C_OUT,       t_true: S_LOAD,   t_false: S_ORD};
            default:  w = '{op: OP_LOAD,   cond: C_LAST_ACC,  t_true: S_FIRST,  t_false: S_LOAD};
        endcase
        return w;
    endfunction

endpackage

### src/mirrored_compare_exchange_sorter.sv
// ------------------------------------------------------------------------
// mirrored_compare_exchange_sorter
// Collects a set of signed words, sorts them ascending with a fixed
// mirrored compare-exchange schedule run by a microcoded sequencer, and
// emits them in order with the final word marked.
// ------------------------------------------------------------------------
//
//  channel | signals                                   | role
//  --------+-------------------------------------------+----------------------
//  in      | in_valid, in_ready, in_value, in_last     | words of one set
//  out     | out_valid, out_ready, out_value, out_last | sorted words
//
// Loading accepts one word per cycle. Each compare-exchange reads both
// entries, then writes low and then writes high when they are out of order,
// on the single store write port; emitting reads each word and then
// registers it out.
// Reset clears the word count and returns the sequencer to loading.
// in_ready is high only while loading; a stalled output word holds in the
// output register and the sequencer waits on it.
module mirrored_compare_exchange_sorter
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [mces_pkg::VAL_W-1:0]  in_value,
    input  logic                               in_last,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [mces_pkg::VAL_W-1:0]  out_value,
    output logic                               out_last
);

    localparam int VAL_W = mces_pkg::VAL_W;
    localparam int IDX_W = mces_pkg::IDX_W;
    localparam int CNT_W = mces_pkg::CNT_W;
    localparam int PC_W  = mces_pkg::PC_W;

    logic [PC_W-1:0]  pc_reg, pc_next;
    logic [PC_W-1:0]  ret_reg, ret_next;
    logic [IDX_W-1:0] a_reg, a_next;
    logic [IDX_W-1:0] b_reg, b_next;
    logic [CNT_W-1:0] r_reg, r_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic                    out_valid_reg, out_valid_next;
    logic signed [VAL_W-1:0] out_value_reg, out_value_next;
    logic                    out_last_reg, out_last_next;

    logic [VAL_W-1:0]        mem [mces_pkg::CAPACITY];
    logic signed [VAL_W-1:0] rd_a_reg, rd_b_reg;

    mces_pkg::uword_t uw;
    logic             in_acc;
    logic             out_free;
    logic             gt;
    logic [CNT_W-1:0] n_m1;
    logic             a_ge_b;
    logic             r_le1;
    logic             r_done;
    logic             last_word;
    logic             cnt_full;

    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [VAL_W-1:0] mem_wdata;
    logic             rd_en;

    assign uw        = mces_pkg::ucode(pc_reg);
    assign in_ready  = (uw.op == mces_pkg::OP_LOAD);
    assign in_acc    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign gt        = rd_a_reg > rd_b_reg;
    assign n_m1      = cnt_reg - CNT_W'(1);
    assign a_ge_b    = a_reg >= b_reg;
    assign r_le1     = r_reg <= CNT_W'(1);
    assign r_done    = r_reg >= n_m1;
    assign last_word = CNT_W'(a_reg) == n_m1;
    assign cnt_full  = cnt_reg >= CNT_W'(mces_pkg::CAPACITY);

    assign out_valid = out_valid_reg;
    assign out_value = out_value_reg;
    assign out_last  = out_last_reg;

    // sequencer: next step from the control word's condition
    always_comb
    begin
        pc_next = uw.t_true;
        case (uw.cond)
            mces_pkg::C_ALWAYS:    pc_next = uw.t_true;
            mces_pkg::C_LAST_ACC:  pc_next = (in_acc && in_last) ? uw.t_true : uw.t_false;
            mces_pkg::C_PASS_DONE: pc_next = a_ge_b ? ret_reg : uw.t_false;
            mces_pkg::C_R_LE1:     pc_next = r_le1 ? uw.t_true : uw.t_false;
            mces_pkg::C_R_DONE:    pc_next = r_done ? uw.t_true : uw.t_false;
            mces_pkg::C_OUT:
            begin
                if (!out_free)
                    pc_next = pc_reg;
                else
                    pc_next = last_word ? uw.t_true : uw.t_false;
            end
            default:               pc_next = mces_pkg::S_LOAD;
        endcase
    end

    // datapath
    always_comb
    begin
        ret_next       = ret_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        r_next         = r_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_value_next = out_value_reg;
        out_last_next  = out_last_reg;
        mem_we         = 1'b0;
        mem_waddr      = a_reg;
        mem_wdata      = rd_b_reg;
        rd_en          = 1'b0;
        case (uw.op)
            mces_pkg::OP_LOAD:
            begin
                // drop words beyond capacity, but keep their last flag
                if (in_acc && !cnt_full)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = cnt_reg[IDX_W-1:0];
                    mem_wdata = in_value;
                    cnt_next  = cnt_reg + CNT_W'(1);
                end
            end
            mces_pkg::OP_FIRST:
            begin
                a_next   = '0;
                b_next   = n_m1[IDX_W-1:0];
                r_next   = n_m1;
                ret_next = mces_pkg::S_FWD;
            end
            mces_pkg::OP_READ:
            begin
                rd_en = !a_ge_b;
            end
            mces_pkg::OP_WR_LO:
            begin
                mem_we    = gt;
                mem_waddr = a_reg;
                mem_wdata = rd_b_reg;
            end
            mces_pkg::OP_WR_HI:
            begin
                mem_we    = gt;
                mem_waddr = b_reg;
                mem_wdata = rd_a_reg;
                a_next    = a_reg + IDX_W'(1);
                b_next    = b_reg - IDX_W'(1);
            end
            mces_pkg::OP_FWD:
            begin
                // prefix pass over [0, r-1]
                if (!r_le1)
                begin
                    a_next = '0;
                    b_next = IDX_W'(r_reg - CNT_W'(1));
                    r_next = r_reg - CNT_W'(1);
                end
            end
            mces_pkg::OP_BINIT:
            begin
                r_next   = CNT_W'(1);
                ret_next = mces_pkg::S_BWD;
            end
            mces_pkg::OP_BWD:
            begin
                // suffix pass over [r, n-1]
                if (!r_done)
                begin
                    a_next = r_reg[IDX_W-1:0];
                    b_next = n_m1[IDX_W-1:0];
                    r_next = r_reg + CNT_W'(1);
                end
            end
            mces_pkg::OP_OSTART:
            begin
                a_next = '0;
            end
            mces_pkg::OP_ORD:
            begin
                rd_en = 1'b1;
            end
            mces_pkg::OP_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = rd_a_reg;
                    out_last_next  = last_word;
                    a_next         = a_reg + IDX_W'(1);
                    if (last_word)
                        cnt_next = '0;
                end
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= mces_pkg::S_LOAD;
            ret_reg       <= mces_pkg::S_FWD;
            a_reg         <= '0;
            b_reg         <= '0;
            r_reg         <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pc_reg        <= pc_next;
            ret_reg       <= ret_next;
            a_reg         <= a_next;
            b_reg         <= b_next;
            r_reg         <= r_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_value_reg <= out_value_next;
        out_last_reg  <= out_last_next;
    end

    // value store: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (rd_en)
        begin
            rd_a_reg <= mem[a_reg];
            rd_b_reg <= mem[b_reg];
        end
    end

`include "mirrored_compare_exchange_sorter_assert.svh"

    `MCES_ASSERT_IMPL(a_cnt_bound, 1'b1, cnt_reg <= CNT_W'(mces_pkg::CAPACITY), "word count above capacity")
    `MCES_ASSERT_IMPL(a_pair_order, pc_reg == mces_pkg::S_WR_HI, a_reg < b_reg, "compare pair out of order")
    `MCES_ASSERT_NEXT(a_cnt_clear, (pc_reg == mces_pkg::S_OUT) && out_free && last_word, (cnt_reg == '0) && out_valid && out_last, "set not closed after last word")

endmodule
